/* src/dlr_pkg.sv */
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants of the DDA line rasteriser.
// ----------------------------------------------------------------------------
package dlr_pkg;

  localparam int COORD_W       = 6;
  localparam int COLOR_W       = 24;
  localparam int CFG_W         = 7;
  localparam int ADDR_W        = 12;
  localparam int CFG_IDX_W     = 1;
  localparam int TILE_SIZE     = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 7'd64;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_DRAW
  } dlr_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_fix;
    logic emit;
  } dlr_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic div_last;
    logic out_free;
    logic line_last;
  } dlr_sts_t;

  function automatic logic [COORD_W-1:0] clip_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W:0] lim;
    lim = (COORD_W+1)'(TILE_SIZE - 1);
    if ({1'b0, v} > lim) begin
      return lim[COORD_W-1:0];
    end
    return v;
  endfunction

endpackage

/* src/dlr_ctrl.sv */
// ----------------------------------------------------------------------------
// dlr_ctrl
// Sequencer: accept a line, run the slope division, step the pixels.
// ----------------------------------------------------------------------------
module dlr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dlr_pkg::dlr_sts_t  sts,
  output dlr_pkg::dlr_cmd_t  cmd
);
  import dlr_pkg::*;

  dlr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !sts.in_zero) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        state_nxt = ST_DRAW;
      end
      ST_DRAW: begin
        if (sts.out_free && sts.line_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_SIGN: cmd.div_fix  = 1'b1;
      ST_DRAW: cmd.emit     = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* src/dlr_datapath.sv */
// ----------------------------------------------------------------------------
// dlr_datapath
// Endpoint set-up, serial slope divider, y accumulator and pixel register.
// ----------------------------------------------------------------------------
module dlr_datapath #(
  parameter int FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dlr_pkg::dlr_cmd_t               cmd,
  output dlr_pkg::dlr_sts_t               sts,
  input  logic [dlr_pkg::COORD_W-1:0]     in_start_x,
  input  logic [dlr_pkg::COORD_W-1:0]     in_start_y,
  input  logic [dlr_pkg::COORD_W-1:0]     in_end_x,
  input  logic [dlr_pkg::COORD_W-1:0]     in_end_y,
  input  logic [dlr_pkg::COLOR_W-1:0]     in_line_color,
  input  logic                            cfg_valid,
  input  logic [dlr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dlr_pkg::CFG_W-1:0]       cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dlr_pkg::COORD_W-1:0]     out_pixel_x,
  output logic [dlr_pkg::COORD_W-1:0]     out_pixel_y,
  output logic [dlr_pkg::ADDR_W-1:0]      out_pixel_address,
  output logic [dlr_pkg::COLOR_W-1:0]     out_pixel_word,
  output logic                            out_in_frame,
  output logic                            out_last
);
  import dlr_pkg::*;

  localparam int NUM_W = COORD_W + FRAC_BITS;
  localparam int Q_W   = NUM_W + 1;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int AF_W  = COORD_W + CFG_W + 1;

  logic [CFG_W-1:0]   fw_r, fh_r;
  logic [COORD_W-1:0] x_cur_r, x_stop_r, div_r, rem_r;
  logic [NUM_W-1:0]   num_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               neg_r;
  logic signed [Q_W-1:0] slope_r, acc_r, acc_nxt;
  logic [COLOR_W-1:0] color_r;
  logic               out_valid_r;

  logic [COORD_W-1:0] sx, sy, ex, ey, cx0, cy0, cx1, cy1;
  logic signed [COORD_W:0] dy;
  logic [COORD_W-1:0] dy_mag;
  logic [COORD_W:0]   rem_sh;
  logic               q_bit;
  logic [COORD_W-1:0] py;
  logic [AF_W-1:0]    addr_full;

  always_comb begin
    cx0 = clip_coord(in_start_x);
    cy0 = clip_coord(in_start_y);
    cx1 = clip_coord(in_end_x);
    cy1 = clip_coord(in_end_y);
    if (cx0 > cx1) begin
      sx = cx1; sy = cy1; ex = cx0; ey = cy0;
    end else begin
      sx = cx0; sy = cy0; ex = cx1; ey = cy1;
    end
    dy     = $signed({1'b0, ey}) - $signed({1'b0, sy});
    dy_mag = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  end

  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign q_bit  = rem_sh >= {1'b0, div_r};

  assign acc_nxt = acc_r + slope_r;
  assign py      = acc_nxt[FRAC_BITS +: COORD_W];
  assign addr_full = AF_W'(py) * AF_W'(fw_r) + AF_W'(x_cur_r);

  assign sts.in_zero   = (cx0 == cx1);
  assign sts.div_last  = (cnt_r == CNT_W'(NUM_W - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.line_last = ({1'b0, x_cur_r} + 1'b1) == {1'b0, x_stop_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_WIDTH_RST;
      fh_r <= FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  fw_r <= cfg_data;
        REG_FRAME_HEIGHT: fh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_cur_r  <= sx;
      x_stop_r <= ex;
      div_r    <= ex - sx;
      rem_r    <= '0;
      num_r    <= {dy_mag, {FRAC_BITS{1'b0}}};
      neg_r    <= dy[COORD_W];
      cnt_r    <= '0;
      acc_r    <= $signed({1'b0, sy, {FRAC_BITS{1'b0}}});
      slope_r  <= '0;
      color_r  <= in_line_color;
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? COORD_W'(rem_sh - {1'b0, div_r}) : rem_sh[COORD_W-1:0];
      num_r <= {num_r[NUM_W-2:0], q_bit};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.div_fix) begin
      slope_r <= neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r});
    end
    if (cmd.emit) begin
      acc_r             <= acc_nxt;
      x_cur_r           <= x_cur_r + 1'b1;
      out_pixel_x       <= x_cur_r;
      out_pixel_y       <= py;
      out_pixel_address <= addr_full[ADDR_W-1:0];
      out_pixel_word    <= color_r;
      out_in_frame      <= ({1'b0, x_cur_r} < fw_r) && ({1'b0, py} < fh_r);
      out_last          <= sts.line_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* src/dda_line_rasterizer_core.sv */
// ----------------------------------------------------------------------------
// dda_line_rasterizer_core
// x-major DDA line rasteriser producing one pixel item per column.
// ----------------------------------------------------------------------------
// A line item is taken only while the block is idle; equal x endpoints give
// no pixels and the block is ready again next cycle. Otherwise the slope is
// formed by a restoring divider at one quotient bit per cycle, the ST_SIGN
// state applies the sign, and then the accumulator emits one pixel per cycle
// while the output is not stalled.
// frame_width and frame_height may be written only while no line is in flight.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_core #(
  parameter int FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dlr_pkg::COORD_W-1:0]     in_start_x,
  input  logic [dlr_pkg::COORD_W-1:0]     in_start_y,
  input  logic [dlr_pkg::COORD_W-1:0]     in_end_x,
  input  logic [dlr_pkg::COORD_W-1:0]     in_end_y,
  input  logic [dlr_pkg::COLOR_W-1:0]     in_line_color,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dlr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dlr_pkg::CFG_W-1:0]       cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dlr_pkg::COORD_W-1:0]     out_pixel_x,
  output logic [dlr_pkg::COORD_W-1:0]     out_pixel_y,
  output logic [dlr_pkg::ADDR_W-1:0]      out_pixel_address,
  output logic [dlr_pkg::COLOR_W-1:0]     out_pixel_word,
  output logic                            out_in_frame,
  output logic                            out_last
);
  import dlr_pkg::*;

  dlr_cmd_t cmd;
  dlr_sts_t sts;

  assign cfg_ready = 1'b1;

  dlr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dlr_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .in_line_color     (in_line_color),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_word    (out_pixel_word),
    .out_in_frame      (out_in_frame),
    .out_last          (out_last)
  );

endmodule

/* tb/dlr_checker.sv */
// ----------------------------------------------------------------------------
// dlr_checker
// Watches the line, pixel and register channels of the DDA line rasteriser.
// Every accepted line item is rasterised here into the pixels it should give;
// every accepted pixel item is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
module dlr_checker
  import dlr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [COORD_W-1:0]   in_start_x,
  input  logic [COORD_W-1:0]   in_start_y,
  input  logic [COORD_W-1:0]   in_end_x,
  input  logic [COORD_W-1:0]   in_end_y,
  input  logic [COLOR_W-1:0]   in_line_color,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [COORD_W-1:0]   out_pixel_x,
  input  logic [COORD_W-1:0]   out_pixel_y,
  input  logic [ADDR_W-1:0]    out_pixel_address,
  input  logic [COLOR_W-1:0]   out_pixel_word,
  input  logic                 out_in_frame,
  input  logic                 out_last,
  output int                   mismatches,
  output int                   pixels_pending,
  output int                   pixels_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q = longint'(1) << FRAC_BITS_DEF;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] word;
    logic               in_frame;
    logic               last;
  } pixel_t;

  pixel_t             pixels_due[$];
  logic [CFG_W-1:0]   frame_w = FRAME_WIDTH_RST;
  logic [CFG_W-1:0]   frame_h = FRAME_HEIGHT_RST;
  longint             slope = 0;
  longint             y_acc = 0;
  logic [CFG_W-1:0]   x_cur = '0;
  logic [CFG_W-1:0]   x_end = '0;
  logic [COLOR_W-1:0] color = '0;
  int                 err_cnt = 0;
  int                 seen_cnt = 0;

  task automatic rasterise(input logic [COORD_W-1:0] sx_i, input logic [COORD_W-1:0] sy_i,
                           input logic [COORD_W-1:0] ex_i, input logic [COORD_W-1:0] ey_i,
                           input logic [COLOR_W-1:0] col_i);
    longint sx, sy, ex, ey, tmp, yi;
    pixel_t p;
    sx = sx_i;
    sy = sy_i;
    ex = ex_i;
    ey = ey_i;
    color = col_i;
    if (sx > ex) begin
      tmp = sx; sx = ex; ex = tmp;
      tmp = sy; sy = ey; ey = tmp;
    end
    x_cur = CFG_W'(sx);
    x_end = CFG_W'(ex);
    y_acc = sy * ONE_Q;
    slope = 0;
    // signed division truncates toward zero
    if (ex != sx) slope = ((ey - sy) * ONE_Q) / (ex - sx);
    while (x_cur < x_end) begin
      y_acc += slope;
      yi = y_acc / ONE_Q;
      p.x = x_cur[COORD_W-1:0];
      p.y = COORD_W'(yi);
      p.addr = ADDR_W'(int'(p.y) * int'(frame_w) + int'(p.x));
      p.word = color;
      p.in_frame = (yi >= 0) && (p.x < frame_w) && (yi < longint'(frame_h));
      p.last = (x_cur + 1'b1 == x_end);
      pixels_due.push_back(p);
      x_cur++;
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (pixels_due.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("%0t: pixel item with none due: x=%0d y=%0d addr=%0d word=%06h f=%0b l=%0b",
                 $realtime, out_pixel_x, out_pixel_y, out_pixel_address, out_pixel_word,
                 out_in_frame, out_last);
      return;
    end
    want = pixels_due.pop_front();
    if (out_pixel_x !== want.x || out_pixel_y !== want.y || out_pixel_address !== want.addr ||
        out_pixel_word !== want.word || out_in_frame !== want.in_frame ||
        out_last !== want.last) begin
      err_cnt++;
      if (err_cnt <= 10) begin
        $display("%0t: pixel mismatch", $realtime);
        $display("  exp x=%0d y=%0d addr=%0d word=%06h f=%0b l=%0b",
                 want.x, want.y, want.addr, want.word, want.in_frame, want.last);
        $display("  got x=%0d y=%0d addr=%0d word=%06h f=%0b l=%0b",
                 out_pixel_x, out_pixel_y, out_pixel_address, out_pixel_word,
                 out_in_frame, out_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_w = FRAME_WIDTH_RST;
      frame_h = FRAME_HEIGHT_RST;
      slope = 0;
      y_acc = 0;
      x_cur = '0;
      x_end = '0;
      color = '0;
      pixels_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_WIDTH) frame_w = cfg_data;
        else if (cfg_index == REG_FRAME_HEIGHT) frame_h = cfg_data;
      end
      if (out_valid && !out_stall) begin
        seen_cnt++;
        check_pixel();
      end
      if (in_valid && !in_stall)
        rasterise(in_start_x, in_start_y, in_end_x, in_end_y, in_line_color);
    end
    mismatches     <= err_cnt;
    pixels_pending <= pixels_due.size();
    pixels_seen    <= seen_cnt;
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the DDA line rasteriser.
// Directed lines (extremes, swaps, equal x, steep and falling slopes) are
// followed by random lines over several frame sizes and idle patterns, with a
// long output hold-off; dlr_checker does the pixel prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dlr_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int SETTLE_CYCLES  = 100;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 8;
  localparam int LINES_PER_PH   = 30;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [COORD_W-1:0]   in_start_x;
  logic [COORD_W-1:0]   in_start_y;
  logic [COORD_W-1:0]   in_end_x;
  logic [COORD_W-1:0]   in_end_y;
  logic [COLOR_W-1:0]   in_line_color;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 out_valid;
  logic                 out_stall;
  logic [COORD_W-1:0]   out_pixel_x;
  logic [COORD_W-1:0]   out_pixel_y;
  logic [ADDR_W-1:0]    out_pixel_address;
  logic [COLOR_W-1:0]   out_pixel_word;
  logic                 out_in_frame;
  logic                 out_last;

  int mismatches;
  int pixels_pending;
  int pixels_seen;
  int lines_sent = 0;
  int sizes_written = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_req = 0;
  int quiet_cycles = 0;
  int width_set[PHASES]  = '{64, 1, 0, 127, 40, 64, 17, 33};
  int height_set[PHASES] = '{64, 1, 0, 127, 23, 64, 50, 9};
  int idle_snd[4] = '{0, 70, 0, 7};
  int idle_rcv[4] = '{0, 0, 70, 7};

  always #(CLK_PERIOD / 2) clk = ~clk;

  dda_line_rasterizer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .in_line_color     (in_line_color),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_word    (out_pixel_word),
    .out_in_frame      (out_in_frame),
    .out_last          (out_last)
  );

  dlr_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .in_line_color     (in_line_color),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_word    (out_pixel_word),
    .out_in_frame      (out_in_frame),
    .out_last          (out_last),
    .mismatches        (mismatches),
    .pixels_pending    (pixels_pending),
    .pixels_seen       (pixels_seen)
  );

  // pixel receiver: random stalls, or one long counted hold-off on request
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", quiet_cycles);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  task automatic push_line(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                           input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                           input logic [COLOR_W-1:0] col);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_start_x    <= sx;
    in_start_y    <= sy;
    in_end_x      <= ex;
    in_end_y      <= ey;
    in_line_color <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lines_sent++;
  endtask

  task automatic push_random_line();
    logic [COORD_W-1:0] sx, sy, ex, ey;
    int kind;
    kind = $urandom_range(9);
    sx = COORD_W'($urandom);
    sy = COORD_W'($urandom);
    ex = COORD_W'($urandom);
    ey = COORD_W'($urandom);
    if (kind < 2) begin
      ex = COORD_W'(sx + $urandom_range(3));
    end else if (kind == 2) begin
      ex = sx;
    end else if (kind == 3) begin
      sx = {COORD_W{1'($urandom)}};
      sy = {COORD_W{1'($urandom)}};
      ex = {COORD_W{1'($urandom)}};
      ey = {COORD_W{1'($urandom)}};
    end
    push_line(sx, sy, ex, ey, COLOR_W'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    // equal-x lines leave nothing due and never take the block out of idle
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sizes_written++;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_start_x    <= '0;
    in_start_y    <= '0;
    in_end_x      <= '0;
    in_end_y      <= '0;
    in_line_color <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_FRAME_WIDTH;
    cfg_data      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    push_line(6'd0,  6'd0,  6'd63, 6'd63, 24'hFFFFFF);
    push_line(6'd63, 6'd63, 6'd0,  6'd0,  24'h000000);
    push_line(6'd0,  6'd63, 6'd63, 6'd0,  24'hA5A5A5);
    push_line(6'd5,  6'd10, 6'd5,  6'd40, 24'h123456);
    push_line(6'd0,  6'd0,  6'd0,  6'd0,  24'h5A5A5A);
    push_line(6'd63, 6'd0,  6'd63, 6'd63, 24'hFFFFFF);
    push_line(6'd0,  6'd0,  6'd1,  6'd63, 24'h00FF00);
    push_line(6'd1,  6'd63, 6'd0,  6'd0,  24'hFF0000);
    push_line(6'd0,  6'd0,  6'd63, 6'd0,  24'h0000FF);
    push_line(6'd10, 6'd20, 6'd30, 6'd21, 24'h808080);
    push_line(6'd0,  6'd32, 6'd63, 6'd31, 24'h7F7F7F);
    push_line(6'd3,  6'd7,  6'd10, 6'd0,  24'h010203);
    push_line(6'd62, 6'd5,  6'd63, 6'd6,  24'hFEDCBA);
    push_line(6'd0,  6'd63, 6'd63, 6'd63, 24'h800001);
    push_line(6'd20, 6'd0,  6'd19, 6'd63, 24'h000001);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) set_frame(CFG_W'(width_set[ph]), CFG_W'(height_set[ph]));
      snd_idle_pct  = idle_snd[ph % 4];
      rcv_stall_pct = idle_rcv[ph % 4];
      if (ph == 2) begin
        // hold the pixel side off while long lines keep coming
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_req = LONG_HOLD;
        repeat (6)
          push_line(COORD_W'($urandom_range(3)), COORD_W'($urandom),
                    COORD_W'(60 + $urandom_range(3)), COORD_W'($urandom),
                    COLOR_W'($urandom));
        drain();
        snd_idle_pct  = idle_snd[ph % 4];
        rcv_stall_pct = idle_rcv[ph % 4];
      end
      repeat (LINES_PER_PH) push_random_line();
    end

    drain();
    $display("%0d lines rasterised into %0d checked pixels, %0d frame sizes written",
             lines_sent, pixels_seen, sizes_written);
    if (mismatches == 0 && pixels_pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches, %0d pixels never arrived", mismatches, pixels_pending);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
